### src/msgpack_value_skipper_top_assert.svh
// ----------------------------------------------------------------------------
// MessagePack value skipper assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef MSGPACK_VALUE_SKIPPER_TOP_ASSERT_SVH
`define MSGPACK_VALUE_SKIPPER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define MSGVS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MSGVS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSGVS_ASSERT(label, clk, rst_n, prop, msg)
`define MSGVS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### src/msgvs_pkg.sv
// ----------------------------------------------------------------------------
// MessagePack value skipper package
// Shared widths, depths and the stack RAM request type.
// ----------------------------------------------------------------------------
package msgvs_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int LEVEL_W     = 6;
	localparam int CNT_W       = 33;
	localparam int LEN_W       = 32;
	localparam int BYTE_W      = 8;
	localparam int STATUS_W    = 3;
	localparam int MAX_DEPTH   = 31;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CNT_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

### src/msgvs_in_if.sv
// ----------------------------------------------------------------------------
// MessagePack value skipper input channel
// Carries one payload byte per word with its end-of-payload mark.
// ----------------------------------------------------------------------------
interface msgvs_in_if;
	import msgvs_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              end_of_payload;

	modport source (output valid, output data_byte, output end_of_payload, input ready);
	modport sink (input valid, input data_byte, input end_of_payload, output ready);
endinterface

### src/msgvs_out_if.sv
// ----------------------------------------------------------------------------
// MessagePack value skipper result channel
// Carries the per-byte status and the open container count.
// ----------------------------------------------------------------------------
interface msgvs_out_if;
	import msgvs_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [LEVEL_W-1:0]  nesting_level;

	modport source (output valid, output status, output nesting_level, input ready);
	modport sink (input valid, input status, input nesting_level, output ready);
endinterface

### src/msgvs_stack_ram.sv
// ----------------------------------------------------------------------------
// MessagePack value skipper stack RAM
// Remaining element counts of open containers, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module msgvs_stack_ram (
	input  logic                        clk,
	input  msgvs_pkg::ram_req_t         req,
	output logic [msgvs_pkg::CNT_W-1:0] rdata
);
	import msgvs_pkg::*;

	logic [CNT_W-1:0] mem_q [STACK_DEPTH];
	logic [CNT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### src/msgvs_core.sv
// ----------------------------------------------------------------------------
// MessagePack value skipper parser core
// Decodes tags and headers, pushes and pops the count stack through the
// stack RAM, and holds the result word until it is taken.
// ----------------------------------------------------------------------------
`include "msgpack_value_skipper_top_assert.svh"

module msgvs_core (
	input  logic                        clk,
	input  logic                        arst_n,
	msgvs_in_if.sink                    stream,
	msgvs_out_if.source                 result,
	output msgvs_pkg::ram_req_t         ram_req,
	input  logic [msgvs_pkg::CNT_W-1:0] ram_rdata
);
	import msgvs_pkg::*;

	localparam logic [STATUS_W-1:0] ST_BUSY   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DONE   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BADTAG = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DEEP   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_TRUNC  = 3'd4;

	localparam logic [2:0] K_TAG  = 3'd0;
	localparam logic [2:0] K_LEN  = 3'd1;
	localparam logic [2:0] K_LENX = 3'd2;
	localparam logic [2:0] K_ARR  = 3'd3;
	localparam logic [2:0] K_MAP  = 3'd4;
	localparam logic [2:0] K_SKIP = 3'd5;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_POP, S_EMIT} state_t;
	typedef enum logic [2:0] {A_NONE, A_FINISH, A_SKIP, A_OPEN, A_HDR, A_ERR} act_t;

	typedef struct packed {
		act_t             act;
		logic [CNT_W-1:0] amt;
		logic [2:0]       kind;
		logic [2:0]       nb;
	} tag_dec_t;

	function automatic tag_dec_t tag_decode(input logic [BYTE_W-1:0] t);
		tag_dec_t d;
		d.act  = A_ERR;
		d.amt  = '0;
		d.kind = K_TAG;
		d.nb   = 3'd0;
		if (t <= 8'h7f || t >= 8'he0 || t == 8'hc0 || t == 8'hc2 || t == 8'hc3) begin
			d.act = A_FINISH;
		end else if ((t & 8'he0) == 8'ha0) begin
			d.act = A_SKIP;
			d.amt = CNT_W'(t[4:0]);
		end else if (t[7:4] == 4'h9) begin
			d.act = A_OPEN;
			d.amt = CNT_W'(t[3:0]);
		end else if (t[7:4] == 4'h8) begin
			d.act = A_OPEN;
			d.amt = CNT_W'({t[3:0], 1'b0});
		end else begin
			unique case (t)
				8'hc4, 8'hd9: begin d.act = A_HDR; d.kind = K_LEN;  d.nb = 3'd1; end
				8'hc5, 8'hda: begin d.act = A_HDR; d.kind = K_LEN;  d.nb = 3'd2; end
				8'hc6, 8'hdb: begin d.act = A_HDR; d.kind = K_LEN;  d.nb = 3'd4; end
				8'hc7: begin d.act = A_HDR; d.kind = K_LENX; d.nb = 3'd1; end
				8'hc8: begin d.act = A_HDR; d.kind = K_LENX; d.nb = 3'd2; end
				8'hc9: begin d.act = A_HDR; d.kind = K_LENX; d.nb = 3'd4; end
				8'hca, 8'hce, 8'hd2: begin d.act = A_SKIP; d.amt = CNT_W'(4); end
				8'hcb, 8'hcf, 8'hd3: begin d.act = A_SKIP; d.amt = CNT_W'(8); end
				8'hcc, 8'hd0: begin d.act = A_SKIP; d.amt = CNT_W'(1); end
				8'hcd, 8'hd1, 8'hd4: begin d.act = A_SKIP; d.amt = CNT_W'(2); end
				8'hd5: begin d.act = A_SKIP; d.amt = CNT_W'(3); end
				8'hd6: begin d.act = A_SKIP; d.amt = CNT_W'(5); end
				8'hd7: begin d.act = A_SKIP; d.amt = CNT_W'(9); end
				8'hd8: begin d.act = A_SKIP; d.amt = CNT_W'(17); end
				8'hdc: begin d.act = A_HDR; d.kind = K_ARR; d.nb = 3'd2; end
				8'hdd: begin d.act = A_HDR; d.kind = K_ARR; d.nb = 3'd4; end
				8'hde: begin d.act = A_HDR; d.kind = K_MAP; d.nb = 3'd2; end
				8'hdf: begin d.act = A_HDR; d.kind = K_MAP; d.nb = 3'd4; end
				default: d.act = A_ERR;
			endcase
		end
		return d;
	endfunction

	state_t              state_q, state_n;
	logic [LEVEL_W-1:0]  level_q, level_n;
	logic [CNT_W-1:0]    skip_q, skip_n;
	logic [2:0]          hl_q, hl_n;
	logic [LEN_W-1:0]    acc_q, acc_n;
	logic [2:0]          kind_q, kind_n;
	logic                err_q, err_n;
	logic [STATUS_W-1:0] st_q, st;
	logic [BYTE_W-1:0]   byte_s1;
	logic                last_s1;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [LEVEL_W-1:0]  out_level_q;

	logic                done, fin, out_free, load, clear_evt, trunc;
	act_t                act;
	logic [CNT_W-1:0]    amt, skip_dec, left;
	logic [STATUS_W-1:0] code;
	logic [2:0]          hkind, hnb, hl_dec;
	logic [LEN_W-1:0]    acc_shift;
	logic [LEVEL_W-1:0]  lvl_m1, lvl_m2;
	tag_dec_t            dec;

	assign lvl_m1 = level_q - LEVEL_W'(1);
	assign lvl_m2 = level_q - LEVEL_W'(2);

	always_comb begin
		state_n   = state_q;
		level_n   = level_q;
		skip_n    = skip_q;
		hl_n      = hl_q;
		acc_n     = acc_q;
		kind_n    = kind_q;
		err_n     = err_q;
		st        = ST_BUSY;
		done      = 1'b0;
		fin       = 1'b0;
		act       = A_NONE;
		amt       = '0;
		code      = ST_BADTAG;
		hkind     = K_TAG;
		hnb       = 3'd0;
		hl_dec    = 3'd0;
		acc_shift = '0;
		skip_dec  = '0;
		left      = '0;
		dec       = '0;
		ram_req   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (stream.valid) begin
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				if (err_q) begin
					st   = kind_q;
					done = 1'b1;
				end else begin
					unique case (kind_q)
						K_LEN, K_LENX, K_ARR, K_MAP: begin
							acc_shift = {acc_q[LEN_W-BYTE_W-1:0], byte_s1};
							acc_n     = acc_shift;
							hl_dec    = (hl_q != 3'd0) ? hl_q - 3'd1 : 3'd0;
							hl_n      = hl_dec;
							if (hl_dec != 3'd0) begin
								act = A_NONE;
							end else begin
								unique case (kind_q)
									K_LEN: begin
										act = A_SKIP;
										amt = {1'b0, acc_shift};
									end
									K_LENX: begin
										act = A_SKIP;
										amt = {1'b0, acc_shift} + CNT_W'(1);
									end
									K_ARR: begin
										act = A_OPEN;
										amt = {1'b0, acc_shift};
									end
									default: begin
										act = A_OPEN;
										amt = {acc_shift, 1'b0};
									end
								endcase
							end
						end
						K_SKIP: begin
							skip_dec = skip_q - CNT_W'(1);
							skip_n   = skip_dec;
							act      = (skip_dec == '0) ? A_FINISH : A_NONE;
						end
						default: begin
							if ({26'd0, level_q} > 32'(MAX_DEPTH)) begin
								act  = A_ERR;
								code = ST_DEEP;
							end else begin
								dec   = tag_decode(byte_s1);
								act   = dec.act;
								amt   = dec.amt;
								hkind = dec.kind;
								hnb   = dec.nb;
							end
						end
					endcase
					unique case (act)
						A_NONE: done = 1'b1;
						A_FINISH: fin = 1'b1;
						A_SKIP: begin
							if (amt == '0) begin
								fin = 1'b1;
							end else begin
								skip_n = amt;
								kind_n = K_SKIP;
								done   = 1'b1;
							end
						end
						A_OPEN: begin
							if (amt == '0) begin
								fin = 1'b1;
							end else if (level_q == LEVEL_W'(STACK_DEPTH)) begin
								err_n  = 1'b1;
								kind_n = ST_DEEP;
								st     = ST_DEEP;
								done   = 1'b1;
							end else begin
								ram_req.we    = 1'b1;
								ram_req.waddr = level_q[ADDR_W-1:0];
								ram_req.wdata = amt;
								level_n       = level_q + LEVEL_W'(1);
								kind_n        = K_TAG;
								done          = 1'b1;
							end
						end
						A_HDR: begin
							kind_n = hkind;
							hl_n   = hnb;
							acc_n  = '0;
							done   = 1'b1;
						end
						default: begin
							err_n  = 1'b1;
							kind_n = code;
							st     = code;
							done   = 1'b1;
						end
					endcase
					// close the value: walk the open containers
					if (fin) begin
						kind_n = K_TAG;
						if (level_q == '0) begin
							st   = ST_DONE;
							done = 1'b1;
						end else begin
							ram_req.re    = 1'b1;
							ram_req.raddr = lvl_m1[ADDR_W-1:0];
							state_n       = S_POP;
						end
					end
				end
			end
			S_POP: begin
				left          = ram_rdata - CNT_W'(1);
				ram_req.we    = 1'b1;
				ram_req.waddr = lvl_m1[ADDR_W-1:0];
				ram_req.wdata = left;
				if (left != '0) begin
					done = 1'b1;
				end else begin
					level_n = lvl_m1;
					if (lvl_m1 == '0) begin
						st   = ST_DONE;
						done = 1'b1;
					end else begin
						ram_req.re    = 1'b1;
						ram_req.raddr = lvl_m2[ADDR_W-1:0];
					end
				end
			end
			S_EMIT: begin
				st   = st_q;
				done = 1'b1;
			end
			default: state_n = S_IDLE;
		endcase
	end

	assign out_free  = !out_valid_q || result.ready;
	assign load      = done && out_free;
	assign clear_evt = load && last_s1;
	assign trunc     = last_s1 && !err_n && (level_n != '0 || kind_n != K_TAG);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			level_q      <= '0;
			skip_q       <= '0;
			hl_q         <= '0;
			acc_q        <= '0;
			kind_q       <= K_TAG;
			err_q        <= 1'b0;
			st_q         <= ST_BUSY;
			byte_s1      <= '0;
			last_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_BUSY;
			out_level_q  <= '0;
		end else begin
			if (result.ready && !load) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_IDLE && stream.valid) begin
				byte_s1 <= stream.data_byte;
				last_s1 <= stream.end_of_payload;
			end
			if (load) begin
				out_valid_q  <= 1'b1;
				out_status_q <= trunc ? ST_TRUNC : st;
				out_level_q  <= level_n;
				state_q      <= S_IDLE;
			end else if (done) begin
				st_q    <= st;
				state_q <= S_EMIT;
			end else begin
				state_q <= state_n;
			end
			// drop the parse state at the end of the payload
			if (clear_evt) begin
				level_q <= '0;
				skip_q  <= '0;
				hl_q    <= '0;
				acc_q   <= '0;
				kind_q  <= K_TAG;
				err_q   <= 1'b0;
			end else begin
				level_q <= level_n;
				skip_q  <= skip_n;
				hl_q    <= hl_n;
				acc_q   <= acc_n;
				kind_q  <= kind_n;
				err_q   <= err_n;
			end
		end
	end

	assign stream.ready         = (state_q == S_IDLE);
	assign result.valid         = out_valid_q;
	assign result.status        = out_status_q;
	assign result.nesting_level = out_level_q;

	`MSGVS_ASSERT(a_level_range, clk, arst_n, level_q <= LEVEL_W'(STACK_DEPTH), "stack level overflow")
	`MSGVS_ASSERT(a_pop_nonempty, clk, arst_n, state_q == S_POP |-> level_q != '0, "pop on empty stack")
	`MSGVS_ASSERT(a_err_sticky, clk, arst_n, err_q && !clear_evt |=> err_q, "error flag dropped early")
	`MSGVS_ASSERT(a_err_code, clk, arst_n, err_q |-> (kind_q == ST_BADTAG || kind_q == ST_DEEP), "bad error code held")
	`MSGVS_ASSERT_ALWAYS(a_ram_split, clk, ram_req.we && ram_req.re |-> ram_req.waddr != ram_req.raddr, "stack read and write collide")
endmodule

### src/msgpack_value_skipper_top.sv
// ----------------------------------------------------------------------------
// MessagePack value skipper top level
// Finds where each complete top-level MessagePack value ends, one byte per
// input word, and reports a status and the open container count per byte.
// ----------------------------------------------------------------------------
// Each byte is first registered and then decoded against the parse state.
// When a byte ends a value inside open containers, the counts are walked in
// the 32-entry stack RAM one container at a time, paced by its synchronous read port.
// The result word waits in an output register, so the next byte is taken
// while the previous result is still unread. The stack RAM needs no clearing
// after reset; the block accepts bytes at once.
module msgpack_value_skipper_top (
	input logic         clk,
	input logic         arst_n,
	msgvs_in_if.sink    stream,
	msgvs_out_if.source result
);
	import msgvs_pkg::*;

	ram_req_t         ram_req;
	logic [CNT_W-1:0] ram_rdata;

	msgvs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream),
		.result    (result),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	msgvs_stack_ram u_stack (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);
endmodule

### test/tb_msgpack_value_skipper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MessagePack value skipper testbench
// Streams directed, deeply nested, well-formed, cut-short and garbage payloads
// into the skipper with random idle bursts on both channels, then back to back.
// A parser model in the bench predicts the status and the open container count
// of every byte, and each result word is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_msgpack_value_skipper_top;
	import msgvs_pkg::*;

	localparam logic [2:0] S_PROGRESS  = 3'd0;
	localparam logic [2:0] S_COMPLETE  = 3'd1;
	localparam logic [2:0] S_BAD_TAG   = 3'd2;
	localparam logic [2:0] S_TOO_DEEP  = 3'd3;
	localparam logic [2:0] S_TRUNCATED = 3'd4;

	localparam logic [2:0] K_TAG     = 3'd0;
	localparam logic [2:0] K_LEN     = 3'd1;
	localparam logic [2:0] K_EXT_LEN = 3'd2;
	localparam logic [2:0] K_ARR_CNT = 3'd3;
	localparam logic [2:0] K_MAP_CNT = 3'd4;
	localparam logic [2:0] K_SKIP    = 3'd5;

	localparam logic [7:0] TAG_FIXMAP   = 8'h80;
	localparam logic [7:0] TAG_FIXARRAY = 8'h90;
	localparam logic [7:0] TAG_FIXSTR   = 8'ha0;
	localparam logic [7:0] TAG_NIL      = 8'hc0;
	localparam logic [7:0] TAG_NEVER    = 8'hc1;
	localparam logic [7:0] TAG_FALSE    = 8'hc2;
	localparam logic [7:0] TAG_TRUE     = 8'hc3;
	localparam logic [7:0] TAG_BIN8     = 8'hc4;
	localparam logic [7:0] TAG_BIN16    = 8'hc5;
	localparam logic [7:0] TAG_BIN32    = 8'hc6;
	localparam logic [7:0] TAG_EXT8     = 8'hc7;
	localparam logic [7:0] TAG_EXT16    = 8'hc8;
	localparam logic [7:0] TAG_EXT32    = 8'hc9;
	localparam logic [7:0] TAG_FLOAT32  = 8'hca;
	localparam logic [7:0] TAG_FLOAT64  = 8'hcb;
	localparam logic [7:0] TAG_UINT8    = 8'hcc;
	localparam logic [7:0] TAG_UINT16   = 8'hcd;
	localparam logic [7:0] TAG_UINT32   = 8'hce;
	localparam logic [7:0] TAG_UINT64   = 8'hcf;
	localparam logic [7:0] TAG_INT8     = 8'hd0;
	localparam logic [7:0] TAG_INT16    = 8'hd1;
	localparam logic [7:0] TAG_INT32    = 8'hd2;
	localparam logic [7:0] TAG_INT64    = 8'hd3;
	localparam logic [7:0] TAG_FIXEXT1  = 8'hd4;
	localparam logic [7:0] TAG_FIXEXT2  = 8'hd5;
	localparam logic [7:0] TAG_FIXEXT4  = 8'hd6;
	localparam logic [7:0] TAG_FIXEXT8  = 8'hd7;
	localparam logic [7:0] TAG_FIXEXT16 = 8'hd8;
	localparam logic [7:0] TAG_STR8     = 8'hd9;
	localparam logic [7:0] TAG_STR16    = 8'hda;
	localparam logic [7:0] TAG_STR32    = 8'hdb;
	localparam logic [7:0] TAG_ARRAY16  = 8'hdc;
	localparam logic [7:0] TAG_ARRAY32  = 8'hdd;
	localparam logic [7:0] TAG_MAP16    = 8'hde;
	localparam logic [7:0] TAG_MAP32    = 8'hdf;
	localparam logic [7:0] TAG_NEGFIX   = 8'he0;

	localparam int QUIET_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 64;
	localparam int RANDOM_WORDS = 1400;
	localparam int TOTAL_WORDS  = 1550;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LEVEL_W-1:0]  level;
	} byte_verdict_t;

	logic clk = 1'b0;
	logic arst_n;

	msgvs_in_if  stream_if ();
	msgvs_out_if result_if ();

	msgpack_value_skipper_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.result (result_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// parser model state
	logic [CNT_W-1:0] open_counts [STACK_DEPTH];
	logic [LEVEL_W-1:0] depth_now = '0;
	logic [CNT_W-1:0]   skip_left = '0;
	logic [2:0]         hdr_left  = '0;
	logic [LEN_W-1:0]   len_acc   = '0;
	logic [2:0]         kind      = K_TAG;
	bit                 err_seen  = 1'b0;

	byte_verdict_t pending_verdicts [$];
	logic [7:0]    payload [$];
	bit            idle_on = 1'b1;
	int            words_sent = 0;
	int            mismatches = 0;
	int            stall_left = 0;
	int            quiet_cycles = 0;

	function automatic logic [2:0] close_value();
		kind = K_TAG;
		while (depth_now > 0 && depth_now <= STACK_DEPTH) begin
			open_counts[depth_now-1] = open_counts[depth_now-1] - 1'b1;
			if (open_counts[depth_now-1] != '0)
				return S_PROGRESS;
			depth_now = depth_now - 1'b1;
		end
		depth_now = '0;
		return S_COMPLETE;
	endfunction

	function automatic logic [2:0] raise_fault(input logic [2:0] code);
		err_seen = 1'b1;
		kind = code;
		return code;
	endfunction

	function automatic logic [2:0] open_box(input logic [CNT_W-1:0] n);
		if (n == '0)
			return close_value();
		if (depth_now >= STACK_DEPTH)
			return raise_fault(S_TOO_DEEP);
		open_counts[depth_now] = n;
		depth_now = depth_now + 1'b1;
		kind = K_TAG;
		return S_PROGRESS;
	endfunction

	function automatic logic [2:0] start_skip(input logic [CNT_W-1:0] n);
		if (n == '0)
			return close_value();
		skip_left = n;
		kind = K_SKIP;
		return S_PROGRESS;
	endfunction

	function automatic logic [2:0] start_header(input logic [2:0] k, input logic [2:0] n);
		kind = k;
		hdr_left = n;
		len_acc = '0;
		return S_PROGRESS;
	endfunction

	function automatic logic [2:0] decode_tag(input logic [7:0] t);
		if (depth_now > MAX_DEPTH)
			return raise_fault(S_TOO_DEEP);
		if (t < TAG_FIXMAP || t >= TAG_NEGFIX || t == TAG_NIL || t == TAG_FALSE ||
				t == TAG_TRUE)
			return close_value();
		if ((t & 8'he0) == TAG_FIXSTR)
			return start_skip(CNT_W'(t & 8'h1f));
		if ((t & 8'hf0) == TAG_FIXARRAY)
			return open_box(CNT_W'(t & 8'h0f));
		if ((t & 8'hf0) == TAG_FIXMAP)
			return open_box(CNT_W'(t & 8'h0f) << 1);
		case (t)
			TAG_BIN8, TAG_STR8: return start_header(K_LEN, 3'd1);
			TAG_BIN16, TAG_STR16: return start_header(K_LEN, 3'd2);
			TAG_BIN32, TAG_STR32: return start_header(K_LEN, 3'd4);
			TAG_EXT8: return start_header(K_EXT_LEN, 3'd1);
			TAG_EXT16: return start_header(K_EXT_LEN, 3'd2);
			TAG_EXT32: return start_header(K_EXT_LEN, 3'd4);
			TAG_FLOAT32, TAG_UINT32, TAG_INT32: return start_skip(33'd4);
			TAG_FLOAT64, TAG_UINT64, TAG_INT64: return start_skip(33'd8);
			TAG_UINT8, TAG_INT8: return start_skip(33'd1);
			TAG_UINT16, TAG_INT16, TAG_FIXEXT1: return start_skip(33'd2);
			TAG_FIXEXT2: return start_skip(33'd3);
			TAG_FIXEXT4: return start_skip(33'd5);
			TAG_FIXEXT8: return start_skip(33'd9);
			TAG_FIXEXT16: return start_skip(33'd17);
			TAG_ARRAY16: return start_header(K_ARR_CNT, 3'd2);
			TAG_ARRAY32: return start_header(K_ARR_CNT, 3'd4);
			TAG_MAP16: return start_header(K_MAP_CNT, 3'd2);
			TAG_MAP32: return start_header(K_MAP_CNT, 3'd4);
			default: return raise_fault(S_BAD_TAG);
		endcase
	endfunction

	function automatic logic [2:0] take_header(input logic [7:0] b);
		len_acc = {len_acc[LEN_W-9:0], b};
		if (hdr_left != '0)
			hdr_left = hdr_left - 1'b1;
		if (hdr_left != '0)
			return S_PROGRESS;
		case (kind)
			K_LEN: return start_skip({1'b0, len_acc});
			K_EXT_LEN: return start_skip({1'b0, len_acc} + 1'b1);
			K_ARR_CNT: return open_box({1'b0, len_acc});
			default: return open_box({len_acc, 1'b0});
		endcase
	endfunction

	function automatic byte_verdict_t parse_byte(input logic [7:0] b, input logic last);
		byte_verdict_t v;
		logic [2:0] st;
		if (err_seen) begin
			st = kind;
		end else begin
			case (kind)
				K_LEN, K_EXT_LEN, K_ARR_CNT, K_MAP_CNT: st = take_header(b);
				K_SKIP: begin
					skip_left = skip_left - 1'b1;
					st = (skip_left == '0) ? close_value() : S_PROGRESS;
				end
				default: st = decode_tag(b);
			endcase
			if (last && !err_seen && (depth_now != '0 || kind != K_TAG))
				st = S_TRUNCATED;
		end
		v.status = st;
		v.level = depth_now;
		if (last) begin
			depth_now = '0;
			skip_left = '0;
			hdr_left = '0;
			len_acc = '0;
			kind = K_TAG;
			err_seen = 1'b0;
		end
		return v;
	endfunction

	function automatic void push_len(input int unsigned n, input int nbytes);
		for (int i = nbytes - 1; i >= 0; i--)
			payload.push_back(8'(n >> (8 * i)));
	endfunction

	function automatic void push_random(input int n);
		repeat (n) payload.push_back(8'($urandom));
	endfunction

	function automatic void emit_value(input int depth);
		int sel;
		int n;
		int k;
		logic [7:0] t;
		sel = $urandom_range(0, (depth >= 3) ? 9 : 13);
		case (sel)
			0: payload.push_back(8'($urandom_range(0, 127)));
			1: payload.push_back(8'($urandom_range(224, 255)));
			2: begin
				k = $urandom_range(0, 2);
				payload.push_back(k == 0 ? TAG_NIL : (k == 1 ? TAG_FALSE : TAG_TRUE));
			end
			3: begin
				n = ($urandom_range(0, 9) == 0) ? 31 : $urandom_range(0, 6);
				payload.push_back(TAG_FIXSTR | 8'(n));
				push_random(n);
			end
			4, 5, 6: begin
				n = $urandom_range(0, 6);
				k = sel - 4;
				if ($urandom_range(0, 1) == 1)
					t = (k == 0) ? TAG_STR8 : ((k == 1) ? TAG_STR16 : TAG_STR32);
				else
					t = (k == 0) ? TAG_BIN8 : ((k == 1) ? TAG_BIN16 : TAG_BIN32);
				payload.push_back(t);
				push_len(n, 1 << k);
				push_random(n);
			end
			7: begin
				n = $urandom_range(0, 6);
				k = $urandom_range(0, 2);
				payload.push_back((k == 0) ? TAG_EXT8 : ((k == 1) ? TAG_EXT16 : TAG_EXT32));
				push_len(n, 1 << k);
				push_random(n + 1);
			end
			8: begin
				k = $urandom_range(0, 4);
				payload.push_back(TAG_FIXEXT1 + 8'(k));
				push_random((1 << k) + 1);
			end
			9: begin
				t = TAG_FLOAT32 + 8'($urandom_range(0, 9));
				payload.push_back(t);
				case (t)
					TAG_UINT8, TAG_INT8: n = 1;
					TAG_UINT16, TAG_INT16: n = 2;
					TAG_FLOAT32, TAG_UINT32, TAG_INT32: n = 4;
					default: n = 8;
				endcase
				push_random(n);
			end
			10: begin
				n = ($urandom_range(0, 19) == 0) ? 15 : $urandom_range(0, 3);
				payload.push_back(TAG_FIXARRAY | 8'(n));
				repeat (n) emit_value(depth + 1);
			end
			11: begin
				n = $urandom_range(0, 2);
				payload.push_back(TAG_FIXMAP | 8'(n));
				repeat (2 * n) emit_value(depth + 1);
			end
			12: begin
				n = $urandom_range(0, 3);
				if ($urandom_range(0, 1) == 1) begin
					payload.push_back(TAG_ARRAY16);
					push_len(n, 2);
				end else begin
					payload.push_back(TAG_ARRAY32);
					push_len(n, 4);
				end
				repeat (n) emit_value(depth + 1);
			end
			default: begin
				n = $urandom_range(0, 2);
				if ($urandom_range(0, 1) == 1) begin
					payload.push_back(TAG_MAP16);
					push_len(n, 2);
				end else begin
					payload.push_back(TAG_MAP32);
					push_len(n, 4);
				end
				repeat (2 * n) emit_value(depth + 1);
			end
		endcase
	endfunction

	task automatic send_word(input logic [7:0] b, input logic last);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			stream_if.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		stream_if.valid <= 1'b1;
		stream_if.data_byte <= b;
		stream_if.end_of_payload <= last;
		do @(posedge clk); while (!stream_if.ready);
		pending_verdicts.push_back(parse_byte(b, last));
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_payload();
		for (int i = 0; i < payload.size(); i++)
			send_word(payload[i], i == payload.size() - 1);
	endtask

	task automatic send_random_payload();
		int r;
		int k;
		payload.delete();
		r = $urandom_range(0, 99);
		if (r < 70) begin
			repeat ($urandom_range(1, 3)) emit_value(0);
		end else if (r < 85) begin
			emit_value(0);
			// cut short
			if (payload.size() > 1)
				payload = payload[0:$urandom_range(0, payload.size() - 2)];
		end else if ($urandom_range(0, 3) == 0) begin
			k = $urandom_range(0, 4);
			case (k)
				0: payload.push_back(TAG_BIN32);
				1: payload.push_back(TAG_STR32);
				2: payload.push_back(TAG_EXT32);
				3: payload.push_back(TAG_ARRAY32);
				default: payload.push_back(TAG_MAP32);
			endcase
			push_random(4);
			push_random($urandom_range(0, 3));
		end else begin
			repeat ($urandom_range(1, 10))
				payload.push_back(($urandom_range(0, 5) == 0) ? TAG_NEVER : 8'($urandom));
		end
		send_payload();
	endtask

	task automatic test_directed();
		payload = '{8'h00};
		send_payload();
		payload = '{8'h7f, TAG_NEGFIX, 8'hff};
		send_payload();
		payload = '{TAG_NIL, TAG_FALSE, TAG_TRUE};
		send_payload();
		// bad tag, then sticky until end of payload
		payload = '{TAG_NEVER, 8'h05, TAG_NIL};
		send_payload();
		payload = '{TAG_FIXARRAY};
		send_payload();
		payload = '{TAG_MAP16, 8'h00, 8'h00};
		send_payload();
		payload = '{TAG_FIXSTR};
		send_payload();
		payload = '{TAG_EXT8, 8'h00, 8'h01};
		send_payload();
		payload = '{TAG_UINT8};
		send_payload();
		payload = '{TAG_FIXMAP | 8'h01, TAG_NIL, TAG_NIL};
		send_payload();
	endtask

	task automatic test_deep_nesting();
		int levels;
		int k;
		repeat (8) begin
			payload.delete();
			levels = $urandom_range(29, 34);
			repeat (levels) begin
				k = $urandom_range(0, 3);
				if (k == 0) begin
					payload.push_back(TAG_ARRAY16);
					push_len(1, 2);
				end else if (k == 1) begin
					payload.push_back(TAG_ARRAY32);
					push_len(1, 4);
				end else begin
					payload.push_back(TAG_FIXARRAY | 8'h01);
				end
			end
			emit_value(3);
			send_payload();
		end
	endtask

	task automatic test_random_payloads();
		while (words_sent < RANDOM_WORDS)
			send_random_payload();
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		while (words_sent < TOTAL_WORDS)
			send_random_payload();
	endtask

	always @(negedge clk) begin
		if (stall_left != 0) begin
			result_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			result_if.ready <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			result_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		byte_verdict_t want;
		if (result_if.valid && result_if.ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("result word with no byte outstanding: status %0d, nesting_level %0d",
					result_if.status, result_if.nesting_level);
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				if (result_if.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result_if.status);
					mismatches++;
				end
				if (result_if.nesting_level !== want.level) begin
					$error("nesting_level: expected %0d, got %0d", want.level,
						result_if.nesting_level);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$error("no word moved for %0d cycles, %0d results outstanding", QUIET_LIMIT,
					pending_verdicts.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		stream_if.valid = 1'b0;
		stream_if.data_byte = '0;
		stream_if.end_of_payload = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_deep_nesting();
		test_random_payloads();
		test_back_to_back();
		stream_if.valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/msgvs_pkg.sv
src/msgvs_in_if.sv
src/msgvs_out_if.sv
src/msgvs_stack_ram.sv
src/msgvs_core.sv
src/msgpack_value_skipper_top.sv
test/tb_msgpack_value_skipper_top.sv
